// ===== rtl/zbpa_pkg.sv =====
// ----------------------------------------------------------------------------
// zbpa_pkg
// Shared types and constants of the zoned bitmap page allocator.
// ----------------------------------------------------------------------------
package zbpa_pkg;

    localparam int ADDR_W         = 48;
    localparam int OP_W           = 2;
    localparam int STATUS_W       = 3;
    localparam int CFG_DATA_W     = 64;

    localparam int ZONE_COUNT_DEF     = 3;
    localparam int PAGES_PER_ZONE_DEF = 4096;
    localparam int PAGE_SHIFT_DEF     = 12;
    // row width is a power of two
    localparam int ROW_BITS_DEF       = 64;

    localparam int S_TDATA_W = ((OP_W + 2 * ADDR_W + 7) / 8) * 8;
    localparam int M_TDATA_W = ((STATUS_W + ADDR_W + 7) / 8) * 8;

    typedef enum logic [OP_W-1:0] {
        OP_ALLOC       = 2'd0,
        OP_FREE_PAGE   = 2'd1,
        OP_RESERVE_RNG = 2'd2,
        OP_FREE_RNG    = 2'd3
    } op_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK         = 3'd0,
        ST_OOM        = 3'd1,
        ST_NOZONE     = 3'd2,
        ST_INCOMPLETE = 3'd3,
        ST_BEYOND     = 3'd4
    } status_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_A_ROW,
        S_A_CHECK,
        S_F_ZONE,
        S_R_ZONE,
        S_R_PAGE,
        S_R_NEXT,
        S_P_CALC,
        S_P_CHECK,
        S_P_WRITE,
        S_DONE
    } state_t;

    typedef struct packed {
        logic    load;
        logic    zone_next;
        logic    row_next;
        logic    mem_read;
        logic    rd_page;
        logic    alloc_write;
        logic    range_setup;
        logic    page_calc;
        logic    page_write;
        logic    page_step;
        logic    zone_done;
        logic    set_status;
        status_t code;
        logic    out_load;
    } cmd_t;

    typedef struct packed {
        op_t  op;
        logic zone_last;
        logic row_ok;
        logic found;
        logic zone_hit;
        logic beyond;
        logic page_more;
        logic rem_zero;
        logic out_free;
    } sts_t;

endpackage

// ===== rtl/zbpa_ctrl.sv =====
// ----------------------------------------------------------------------------
// zbpa_ctrl
// Sequencer for alloc, free and range requests of the page allocator.
// ----------------------------------------------------------------------------
module zbpa_ctrl (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           req_valid,
    output logic           req_ready,
    input  zbpa_pkg::sts_t sts,
    output zbpa_pkg::cmd_t cmd
);

    zbpa_pkg::state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= zbpa_pkg::S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            zbpa_pkg::S_IDLE: begin
                if (req_valid) begin
                    case (sts.op)
                        zbpa_pkg::OP_ALLOC:     state_next = zbpa_pkg::S_A_ROW;
                        zbpa_pkg::OP_FREE_PAGE: state_next = zbpa_pkg::S_F_ZONE;
                        default:                state_next = zbpa_pkg::S_R_ZONE;
                    endcase
                end
            end
            zbpa_pkg::S_A_ROW: begin
                if (sts.row_ok) begin
                    state_next = zbpa_pkg::S_A_CHECK;
                end else if (sts.zone_last) begin
                    state_next = zbpa_pkg::S_DONE;
                end
            end
            zbpa_pkg::S_A_CHECK: begin
                state_next = sts.found ? zbpa_pkg::S_DONE : zbpa_pkg::S_A_ROW;
            end
            zbpa_pkg::S_F_ZONE: begin
                if (sts.zone_hit) begin
                    state_next = zbpa_pkg::S_P_CALC;
                end else if (sts.zone_last) begin
                    state_next = zbpa_pkg::S_DONE;
                end
            end
            zbpa_pkg::S_R_ZONE: begin
                state_next = sts.zone_hit ? zbpa_pkg::S_R_PAGE : zbpa_pkg::S_R_NEXT;
            end
            zbpa_pkg::S_R_PAGE: begin
                state_next = sts.page_more ? zbpa_pkg::S_P_CALC : zbpa_pkg::S_R_NEXT;
            end
            zbpa_pkg::S_R_NEXT: begin
                state_next = sts.zone_last ? zbpa_pkg::S_DONE : zbpa_pkg::S_R_ZONE;
            end
            zbpa_pkg::S_P_CALC: begin
                state_next = zbpa_pkg::S_P_CHECK;
            end
            zbpa_pkg::S_P_CHECK: begin
                state_next = sts.beyond ? zbpa_pkg::S_DONE : zbpa_pkg::S_P_WRITE;
            end
            zbpa_pkg::S_P_WRITE: begin
                state_next = (sts.op == zbpa_pkg::OP_FREE_PAGE) ? zbpa_pkg::S_DONE
                                                                : zbpa_pkg::S_R_PAGE;
            end
            zbpa_pkg::S_DONE: begin
                if (sts.out_free) begin
                    state_next = zbpa_pkg::S_IDLE;
                end
            end
            default: state_next = zbpa_pkg::S_IDLE;
        endcase
    end

    always_comb begin
        cmd       = '0;
        cmd.code  = zbpa_pkg::ST_OK;
        req_ready = 1'b0;
        case (state_reg)
            zbpa_pkg::S_IDLE: begin
                req_ready = 1'b1;
                cmd.load  = req_valid;
            end
            zbpa_pkg::S_A_ROW: begin
                if (sts.row_ok) begin
                    cmd.mem_read = 1'b1;
                end else if (sts.zone_last) begin
                    cmd.set_status = 1'b1;
                    cmd.code       = zbpa_pkg::ST_OOM;
                end else begin
                    cmd.zone_next = 1'b1;
                end
            end
            zbpa_pkg::S_A_CHECK: begin
                if (sts.found) begin
                    cmd.alloc_write = 1'b1;
                    cmd.set_status  = 1'b1;
                    cmd.code        = zbpa_pkg::ST_OK;
                end else begin
                    cmd.row_next = 1'b1;
                end
            end
            zbpa_pkg::S_F_ZONE: begin
                if (sts.zone_hit) begin
                    cmd.range_setup = 1'b1;
                end else if (sts.zone_last) begin
                    cmd.set_status = 1'b1;
                    cmd.code       = zbpa_pkg::ST_NOZONE;
                end else begin
                    cmd.zone_next = 1'b1;
                end
            end
            zbpa_pkg::S_R_ZONE: begin
                cmd.range_setup = sts.zone_hit;
            end
            zbpa_pkg::S_R_PAGE: begin
                cmd.zone_done = !sts.page_more;
            end
            zbpa_pkg::S_R_NEXT: begin
                if (sts.zone_last) begin
                    cmd.set_status = 1'b1;
                    cmd.code       = sts.rem_zero ? zbpa_pkg::ST_OK
                                                  : zbpa_pkg::ST_INCOMPLETE;
                end else begin
                    cmd.zone_next = 1'b1;
                end
            end
            zbpa_pkg::S_P_CALC: begin
                cmd.page_calc = 1'b1;
            end
            zbpa_pkg::S_P_CHECK: begin
                if (sts.beyond) begin
                    cmd.set_status = 1'b1;
                    cmd.code       = zbpa_pkg::ST_BEYOND;
                end else begin
                    cmd.mem_read = 1'b1;
                    cmd.rd_page  = 1'b1;
                end
            end
            zbpa_pkg::S_P_WRITE: begin
                cmd.page_write = 1'b1;
                cmd.page_step  = 1'b1;
                if (sts.op == zbpa_pkg::OP_FREE_PAGE) begin
                    cmd.set_status = 1'b1;
                    cmd.code       = zbpa_pkg::ST_OK;
                end
            end
            zbpa_pkg::S_DONE: begin
                cmd.out_load = sts.out_free;
            end
            default: begin
                cmd = '0;
            end
        endcase
    end

endmodule

// ===== rtl/zbpa_dp.sv =====
// ----------------------------------------------------------------------------
// zbpa_dp
// Datapath: zone walk, bitmap row memory, page stepping and result register.
// ----------------------------------------------------------------------------
module zbpa_dp #(
    parameter int ZONE_COUNT     = zbpa_pkg::ZONE_COUNT_DEF,
    parameter int PAGES_PER_ZONE = zbpa_pkg::PAGES_PER_ZONE_DEF,
    parameter int PAGE_SHIFT     = zbpa_pkg::PAGE_SHIFT_DEF,
    parameter int ROW_BITS       = zbpa_pkg::ROW_BITS_DEF
) (
    input  logic                                             aclk,
    input  logic                                             aresetn,
    input  logic [ZONE_COUNT-1:0][zbpa_pkg::ADDR_W-1:0]      zone_start,
    input  logic [ZONE_COUNT-1:0][zbpa_pkg::ADDR_W-1:0]      zone_end,
    input  zbpa_pkg::op_t                                    in_op,
    input  logic [zbpa_pkg::ADDR_W-1:0]                      in_address,
    input  logic [zbpa_pkg::ADDR_W-1:0]                      in_length,
    input  zbpa_pkg::cmd_t                                   cmd,
    output zbpa_pkg::sts_t                                   sts,
    output logic                                             out_valid,
    input  logic                                             out_ready,
    output zbpa_pkg::status_t                                out_status,
    output logic [zbpa_pkg::ADDR_W-1:0]                      out_page_address
);

    localparam int AW         = zbpa_pkg::ADDR_W;
    localparam int RPZ        = (PAGES_PER_ZONE + ROW_BITS - 1) / ROW_BITS;
    localparam int ROW_COUNT  = ZONE_COUNT * RPZ;
    localparam int RA_W       = (ROW_COUNT > 1) ? $clog2(ROW_COUNT) : 1;
    localparam int R_W        = $clog2(RPZ + 1);
    localparam int Z_W        = (ZONE_COUNT > 1) ? $clog2(ZONE_COUNT) : 1;
    localparam int ROW_SHIFT  = $clog2(ROW_BITS);
    localparam int PIDX_W     = $clog2(PAGES_PER_ZONE);
    localparam int LAST_COLS  = PAGES_PER_ZONE - (RPZ - 1) * ROW_BITS;
    localparam logic [AW:0] PAGE_BYTES = (AW + 1)'(1) << PAGE_SHIFT;
    localparam logic [AW:0] ROW_BYTES  = (AW + 1)'(ROW_BITS) << PAGE_SHIFT;

    zbpa_pkg::op_t          op_reg;
    logic [AW-1:0]          cur_reg, rem_reg, stop_reg;
    logic [AW:0]            off_reg, rowoff_reg;
    logic [Z_W-1:0]         zone_reg;
    logic [RA_W-1:0]        rowbase_reg;
    logic [R_W-1:0]         row_reg;
    logic [PIDX_W-1:0]      idxbase_reg, pidx_reg;
    logic                   beyond_reg;
    zbpa_pkg::status_t      status_reg, out_status_reg;
    logic [AW-1:0]          page_reg, out_page_reg;
    logic                   out_valid_reg;

    logic [ROW_BITS-1:0]    mem [ROW_COUNT];
    logic [ROW_COUNT-1:0]   vld_reg;
    logic [ROW_BITS-1:0]    mem_q_reg;
    logic                   vld_q_reg;

    logic [AW-1:0]          zstart, zend, pdiff, pshift;
    logic [AW:0]            rng_sum;
    logic [RA_W-1:0]        arow, prow, raddr;
    logic [ROW_BITS-1:0]    word, free_vec, alloc_word, page_word;
    logic [ROW_SHIFT-1:0]   acol, pcol;
    logic                   found;
    logic [PIDX_W-1:0]      aidx;
    int                     cols_lim;

    assign zstart = zone_start[zone_reg];
    assign zend   = zone_end[zone_reg];

    assign arow = rowbase_reg + RA_W'(row_reg);
    assign prow = rowbase_reg + RA_W'(pidx_reg >> ROW_SHIFT);
    assign pcol = pidx_reg[ROW_SHIFT-1:0];
    assign raddr = cmd.rd_page ? prow : arow;

    assign word = vld_q_reg ? mem_q_reg : '1;

    always_comb begin
        cols_lim = (int'(row_reg) == RPZ - 1) ? LAST_COLS : ROW_BITS;
        for (int c = 0; c < ROW_BITS; c++) begin
            free_vec[c] = !word[ROW_BITS-1-c] && (c < cols_lim);
        end
        found = 1'b0;
        acol  = '0;
        for (int c = ROW_BITS - 1; c >= 0; c--) begin
            if (free_vec[c]) begin
                found = 1'b1;
                acol  = ROW_SHIFT'(c);
            end
        end
    end

    assign aidx       = idxbase_reg + PIDX_W'(acol);
    assign alloc_word = word | (ROW_BITS'(1) << (ROW_BITS - 1 - int'(acol)));
    assign page_word  = (op_reg == zbpa_pkg::OP_RESERVE_RNG)
                      ? (word | (ROW_BITS'(1) << (ROW_BITS - 1 - int'(pcol))))
                      : (word & ~(ROW_BITS'(1) << (ROW_BITS - 1 - int'(pcol))));

    assign pdiff   = off_reg[AW-1:0] - zstart;
    assign pshift  = pdiff >> PAGE_SHIFT;
    assign rng_sum = {1'b0, cur_reg} + {1'b0, rem_reg};

    always_comb begin
        sts.op        = cmd.load ? in_op : op_reg;
        sts.zone_last = (int'(zone_reg) == ZONE_COUNT - 1);
        sts.row_ok    = (zend > zstart) && (int'(row_reg) < RPZ)
                        && (rowoff_reg < {1'b0, zend - zstart});
        sts.found     = found;
        sts.zone_hit  = (zstart <= cur_reg) && (cur_reg < zend);
        sts.beyond    = beyond_reg;
        sts.page_more = off_reg < {1'b0, stop_reg};
        sts.rem_zero  = (rem_reg == '0);
        sts.out_free  = !out_valid_reg || out_ready;
    end

    // bitmap rows, unwritten rows read as all used
    always_ff @(posedge aclk) begin
        if (cmd.mem_read) begin
            mem_q_reg <= mem[raddr];
        end
        if (cmd.alloc_write) begin
            mem[arow] <= alloc_word;
        end else if (cmd.page_write) begin
            mem[prow] <= page_word;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg   <= '0;
            vld_q_reg <= 1'b0;
        end else begin
            if (cmd.mem_read) begin
                vld_q_reg <= vld_reg[raddr];
            end
            if (cmd.alloc_write) begin
                vld_reg[arow] <= 1'b1;
            end else if (cmd.page_write) begin
                vld_reg[prow] <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            op_reg      <= in_op;
            cur_reg     <= (in_op == zbpa_pkg::OP_FREE_PAGE) ? in_address
                         : (in_address & ~((AW'(1) << PAGE_SHIFT) - AW'(1)));
            rem_reg     <= in_length;
            zone_reg    <= '0;
            rowbase_reg <= '0;
            row_reg     <= '0;
            idxbase_reg <= '0;
            rowoff_reg  <= '0;
            page_reg    <= '0;
        end
        if (cmd.zone_next) begin
            zone_reg    <= zone_reg + Z_W'(1);
            rowbase_reg <= rowbase_reg + RA_W'(RPZ);
            row_reg     <= '0;
            idxbase_reg <= '0;
            rowoff_reg  <= '0;
        end
        if (cmd.row_next) begin
            row_reg     <= row_reg + R_W'(1);
            idxbase_reg <= idxbase_reg + PIDX_W'(ROW_BITS);
            rowoff_reg  <= rowoff_reg + ROW_BYTES;
        end
        if (cmd.alloc_write) begin
            page_reg <= zstart + (AW'(aidx) << PAGE_SHIFT);
        end
        if (cmd.range_setup) begin
            stop_reg <= (rng_sum > {1'b0, zend}) ? zend : rng_sum[AW-1:0];
            off_reg  <= {1'b0, cur_reg};
        end
        if (cmd.page_calc) begin
            pidx_reg   <= pshift[PIDX_W-1:0];
            beyond_reg <= pshift >= AW'(PAGES_PER_ZONE);
        end
        if (cmd.page_step) begin
            off_reg <= off_reg + PAGE_BYTES;
        end
        if (cmd.zone_done) begin
            rem_reg <= rem_reg - (stop_reg - cur_reg);
            cur_reg <= stop_reg;
        end
        if (cmd.set_status) begin
            status_reg <= cmd.code;
        end
        if (cmd.out_load) begin
            out_status_reg <= status_reg;
            out_page_reg   <= page_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (cmd.out_load) begin
            out_valid_reg <= 1'b1;
        end else if (out_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    assign out_valid        = out_valid_reg;
    assign out_status       = out_status_reg;
    assign out_page_address = out_page_reg;

endmodule

// ===== rtl/zoned_bitmap_page_allocator.sv =====
// ----------------------------------------------------------------------------
// zoned_bitmap_page_allocator
// Physical page allocator over configurable zones with used-page bitmaps.
// ----------------------------------------------------------------------------
// One request at a time. Alloc scans the bitmap rows zone by zone, free page
// walks the zones to the one that holds the address, and range requests step
// page by page through each zone the range touches.
// All bitmap work goes through one single-port row memory with registered read.
// Every page reads as used after reset with no clearing pass; software frees
// each zone's range before allocating. Zone registers are 64-bit APB words at
// byte address 8*i (start of zone z at 16*z, end at 16*z+8).
// ----------------------------------------------------------------------------
module zoned_bitmap_page_allocator #(
    parameter int ZONE_COUNT     = zbpa_pkg::ZONE_COUNT_DEF,
    parameter int PAGES_PER_ZONE = zbpa_pkg::PAGES_PER_ZONE_DEF,
    parameter int PAGE_SHIFT     = zbpa_pkg::PAGE_SHIFT_DEF,
    parameter int ROW_BITS       = zbpa_pkg::ROW_BITS_DEF,
    localparam int PADDR_W       = $clog2(16 * ZONE_COUNT)
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    // operation, address, length
    input  logic [zbpa_pkg::S_TDATA_W-1:0]     s_tdata,
    output logic                               m_tvalid,
    input  logic                               m_tready,
    // status, page_address
    output logic [zbpa_pkg::M_TDATA_W-1:0]     m_tdata,
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [PADDR_W-1:0]                 paddr,
    input  logic [zbpa_pkg::CFG_DATA_W-1:0]    pwdata,
    output logic [zbpa_pkg::CFG_DATA_W-1:0]    prdata,
    output logic                               pready
);

    localparam int AW = zbpa_pkg::ADDR_W;

    logic [ZONE_COUNT-1:0][AW-1:0] zone_start_reg, zone_end_reg;
    logic [PADDR_W-4:0]            cfg_idx;
    logic                          cfg_wr;
    zbpa_pkg::cmd_t                cmd;
    zbpa_pkg::sts_t                sts;
    zbpa_pkg::status_t             out_status;
    logic [AW-1:0]                 out_page;

    assign pready  = 1'b1;
    assign cfg_idx = paddr[PADDR_W-1:3];
    assign cfg_wr  = psel && penable && pwrite && pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            zone_start_reg <= '0;
            zone_end_reg   <= '0;
        end else if (cfg_wr) begin
            for (int z = 0; z < ZONE_COUNT; z++) begin
                if (int'(cfg_idx) == 2 * z) begin
                    zone_start_reg[z] <= pwdata[AW-1:0];
                end
                if (int'(cfg_idx) == 2 * z + 1) begin
                    zone_end_reg[z] <= pwdata[AW-1:0];
                end
            end
        end
    end

    always_comb begin
        prdata = '0;
        for (int z = 0; z < ZONE_COUNT; z++) begin
            if (int'(cfg_idx) == 2 * z) begin
                prdata = zbpa_pkg::CFG_DATA_W'(zone_start_reg[z]);
            end
            if (int'(cfg_idx) == 2 * z + 1) begin
                prdata = zbpa_pkg::CFG_DATA_W'(zone_end_reg[z]);
            end
        end
    end

    zbpa_ctrl u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .req_valid (s_tvalid),
        .req_ready (s_tready),
        .sts       (sts),
        .cmd       (cmd)
    );

    zbpa_dp #(
        .ZONE_COUNT     (ZONE_COUNT),
        .PAGES_PER_ZONE (PAGES_PER_ZONE),
        .PAGE_SHIFT     (PAGE_SHIFT),
        .ROW_BITS       (ROW_BITS)
    ) u_dp (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .zone_start       (zone_start_reg),
        .zone_end         (zone_end_reg),
        .in_op            (zbpa_pkg::op_t'(s_tdata[zbpa_pkg::OP_W-1:0])),
        .in_address       (s_tdata[zbpa_pkg::OP_W +: AW]),
        .in_length        (s_tdata[zbpa_pkg::OP_W + AW +: AW]),
        .cmd              (cmd),
        .sts              (sts),
        .out_valid        (m_tvalid),
        .out_ready        (m_tready),
        .out_status       (out_status),
        .out_page_address (out_page)
    );

    assign m_tdata = zbpa_pkg::M_TDATA_W'({out_page, out_status});

`ifndef NO_ASSERTIONS
    a_busy_after_request: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("request accepted while previous one still in work");

    a_page_only_on_ok: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (out_status != zbpa_pkg::ST_OK) |-> (out_page == '0))
        else $error("page address set on failed request");

    a_single_command: assert property (@(posedge aclk) disable iff (!aresetn)
        !(cmd.alloc_write && cmd.page_write))
        else $error("two bitmap writes in one cycle");
`endif

endmodule

// ===== sim/zbpa_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// zbpa_checker
// Watches the request, result and register ports of the page allocator,
// keeps its own copy of the zone registers and used-page bitmap, predicts
// the status and page address of every request and compares each result.
// ----------------------------------------------------------------------------
module zbpa_checker (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_tvalid,
    input  logic                            s_tready,
    // operation, address, length
    input  logic [zbpa_pkg::S_TDATA_W-1:0]  s_tdata,
    input  logic                            m_tvalid,
    input  logic                            m_tready,
    // status, page_address
    input  logic [zbpa_pkg::M_TDATA_W-1:0]  m_tdata,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [5:0]                      paddr,
    input  logic [zbpa_pkg::CFG_DATA_W-1:0] pwdata,
    output int                              fail_count,
    output int                              pending_count,
    output int                              result_count
);

    localparam int ZONES = zbpa_pkg::ZONE_COUNT_DEF;
    localparam int PAGES = zbpa_pkg::PAGES_PER_ZONE_DEF;
    localparam int PSH   = zbpa_pkg::PAGE_SHIFT_DEF;
    localparam int RB    = zbpa_pkg::ROW_BITS_DEF;
    localparam int ZROWS = (PAGES + RB - 1) / RB;
    localparam logic [63:0] AMASK = 64'hFFFF_FFFF_FFFF;

    typedef struct {
        zbpa_pkg::status_t st;
        logic [47:0]       pa;
    } alloc_result_t;

    logic [RB-1:0] page_map [ZONES*ZROWS];
    logic [63:0]   zs [ZONES];
    logic [63:0]   ze [ZONES];
    alloc_result_t expected_results [$];

    function automatic void mark_page(int z, logic [63:0] idx, bit used);
        page_map[z*ZROWS + int'(idx / RB)][RB-1 - int'(idx % RB)] = used;
    endfunction

    function automatic zbpa_pkg::status_t take_page(output logic [47:0] pa);
        logic [63:0] span;
        logic [63:0] rows;
        logic [63:0] idx;
        pa = '0;
        for (int z = 0; z < ZONES; z++) begin
            if (ze[z] <= zs[z]) continue;
            span = ze[z] - zs[z];
            rows = (span + (64'(RB) << PSH) - 1) / (64'(RB) << PSH);
            if (rows > ZROWS) rows = ZROWS;
            for (int r = 0; r < int'(rows); r++) begin
                for (int c = 0; c < RB; c++) begin
                    idx = 64'(r * RB + c);
                    if (idx >= PAGES) break;
                    if (!page_map[z*ZROWS + r][RB-1-c]) begin
                        mark_page(z, idx, 1'b1);
                        pa = 48'((zs[z] + (idx << PSH)) & AMASK);
                        return zbpa_pkg::ST_OK;
                    end
                end
            end
        end
        return zbpa_pkg::ST_OOM;
    endfunction

    function automatic zbpa_pkg::status_t release_page(logic [63:0] a);
        logic [63:0] idx;
        for (int z = 0; z < ZONES; z++) begin
            if (zs[z] <= a && a < ze[z]) begin
                idx = (a - zs[z]) >> PSH;
                if (idx >= PAGES) return zbpa_pkg::ST_BEYOND;
                mark_page(z, idx, 1'b0);
                return zbpa_pkg::ST_OK;
            end
        end
        return zbpa_pkg::ST_NOZONE;
    endfunction

    function automatic zbpa_pkg::status_t walk_range(logic [63:0] base, logic [63:0] size,
                                                     bit used);
        logic [63:0] cur;
        logic [63:0] rem;
        logic [63:0] stop;
        logic [63:0] idx;
        cur = base & ~((64'd1 << PSH) - 1);
        rem = size;
        for (int z = 0; z < ZONES; z++) begin
            if (!(zs[z] <= cur && cur < ze[z])) continue;
            stop = cur + rem;
            if (stop > ze[z]) stop = ze[z];
            for (logic [63:0] off = cur; off < stop; off += (64'd1 << PSH)) begin
                idx = (off - zs[z]) >> PSH;
                if (idx >= PAGES) return zbpa_pkg::ST_BEYOND;
                mark_page(z, idx, used);
            end
            rem -= stop - cur;
            cur = stop;
        end
        return (rem == 0) ? zbpa_pkg::ST_OK : zbpa_pkg::ST_INCOMPLETE;
    endfunction

    always @(posedge aclk) begin
        zbpa_pkg::op_t     op;
        logic [63:0]       a;
        logic [63:0]       len;
        alloc_result_t     exp_r;
        zbpa_pkg::status_t got_st;
        logic [47:0]       got_pa;
        if (!aresetn) begin
            for (int i = 0; i < ZONES*ZROWS; i++) page_map[i] = '1;
            for (int z = 0; z < ZONES; z++) begin
                zs[z] = '0;
                ze[z] = '0;
            end
            expected_results.delete();
            fail_count   = 0;
            result_count = 0;
        end else begin
            if (psel && penable && pwrite && (paddr >> 3) < 2*ZONES) begin
                if ((paddr >> 3) & 1) ze[paddr >> 4] = pwdata & AMASK;
                else                  zs[paddr >> 4] = pwdata & AMASK;
            end
            if (s_tvalid && s_tready) begin
                op    = zbpa_pkg::op_t'(s_tdata[1:0]);
                a     = 64'(s_tdata[49:2]);
                len   = 64'(s_tdata[97:50]);
                exp_r.pa = '0;
                case (op)
                    zbpa_pkg::OP_ALLOC:       exp_r.st = take_page(exp_r.pa);
                    zbpa_pkg::OP_FREE_PAGE:   exp_r.st = release_page(a);
                    zbpa_pkg::OP_RESERVE_RNG: exp_r.st = walk_range(a, len, 1'b1);
                    default:                  exp_r.st = walk_range(a, len, 1'b0);
                endcase
                expected_results.push_back(exp_r);
            end
            if (m_tvalid && m_tready) begin
                got_st = zbpa_pkg::status_t'(m_tdata[2:0]);
                got_pa = m_tdata[50:3];
                result_count++;
                if (expected_results.size() == 0) begin
                    $error("unexpected result: status %0d page_address %h", got_st, got_pa);
                    fail_count++;
                end else begin
                    exp_r = expected_results.pop_front();
                    if (got_st !== exp_r.st) begin
                        $error("status: expected %0d actual %0d", exp_r.st, got_st);
                        fail_count++;
                    end
                    if (got_pa !== exp_r.pa) begin
                        $error("page_address: expected %h actual %h", exp_r.pa, got_pa);
                        fail_count++;
                    end
                end
            end
        end
        pending_count = expected_results.size();
    end

endmodule

// ===== sim/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Stimulus for the zoned bitmap page allocator: several zone layouts,
// directed corner requests and bursty random traffic with receiver stalls.
// ----------------------------------------------------------------------------
module tb_top;

    localparam int          WATCHDOG  = 200000;
    localparam logic [63:0] PG        = 64'd4096;
    localparam logic [63:0] AMASK     = 64'hFFFF_FFFF_FFFF;

    logic                            aclk = 1'b0;
    logic                            aresetn = 1'b0;
    logic                            s_tvalid = 1'b0;
    logic                            s_tready;
    logic [zbpa_pkg::S_TDATA_W-1:0]  s_tdata = '0;
    logic                            m_tvalid;
    logic                            m_tready = 1'b0;
    logic [zbpa_pkg::M_TDATA_W-1:0]  m_tdata;
    logic                            psel = 1'b0;
    logic                            penable = 1'b0;
    logic                            pwrite = 1'b0;
    logic [5:0]                      paddr = '0;
    logic [zbpa_pkg::CFG_DATA_W-1:0] pwdata = '0;
    logic [zbpa_pkg::CFG_DATA_W-1:0] prdata;
    logic                            pready;

    int          fail_count;
    int          pending_count;
    int          result_count;
    int          idle_cycles = 0;
    int          gap_left = 0;
    logic [63:0] zs [3];
    logic [63:0] ze [3];

    always #10 aclk = ~aclk;

    zoned_bitmap_page_allocator u_dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    zbpa_checker u_checker (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .fail_count(fail_count), .pending_count(pending_count),
        .result_count(result_count)
    );

    function automatic logic [63:0] rand48();
        return {$urandom, $urandom} & AMASK;
    endfunction

    // result side stall pattern, with one long hold-off
    initial begin
        int  mode;
        bit  held;
        held = 0;
        mode = 0;
        forever begin
            @(negedge aclk);
            if (!held && result_count >= 150) begin
                held = 1;
                m_tready <= 1'b0;
                repeat (600) @(negedge aclk);
            end
            if ($urandom_range(0, 63) == 0) mode = $urandom_range(0, 2);
            case (mode)
                0:       m_tready <= 1'b1;
                1:       m_tready <= $urandom_range(0, 1);
                default: m_tready <= ($urandom_range(0, 3) != 0);
            endcase
        end
    end

    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (psel && penable))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG) begin
            $display("== FAIL ==");
            $finish;
        end
    end

    task automatic reg_write(int idx, logic [63:0] val);
        @(negedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= 6'(idx * 8);
        pwdata  <= val;
        @(negedge aclk);
        penable <= 1'b1;
        @(negedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (idx & 1) ze[idx >> 1] = val & AMASK;
        else         zs[idx >> 1] = val & AMASK;
    endtask

    task automatic set_zones(logic [63:0] s0, e0, s1, e1, s2, e2);
        reg_write(0, s0); reg_write(1, e0);
        reg_write(2, s1); reg_write(3, e1);
        reg_write(4, s2); reg_write(5, e2);
    endtask

    task automatic send_req(zbpa_pkg::op_t op, logic [63:0] a, logic [63:0] len);
        if (gap_left > 0) begin
            @(negedge aclk);
            s_tvalid <= 1'b0;
            repeat (gap_left - 1) @(negedge aclk);
            gap_left = 0;
        end
        @(negedge aclk);
        s_tvalid <= 1'b1;
        s_tdata  <= {6'd0, len[47:0], a[47:0], op};
        do @(posedge aclk); while (!s_tready);
        if ($urandom_range(0, 9) == 0)
            gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
    endtask

    task automatic drain();
        @(negedge aclk);
        s_tvalid <= 1'b0;
        gap_left = 0;
        while (pending_count != 0) @(negedge aclk);
        repeat (20) @(negedge aclk);
    endtask

    function automatic logic [63:0] zone_addr(int z);
        logic [63:0] span;
        span = (ze[z] > zs[z]) ? ze[z] - zs[z] : 64'd0;
        if (span == 0 || $urandom_range(0, 19) == 0) return rand48();
        if (span > 80 * PG) span = 80 * PG;
        return zs[z] + ({$urandom, $urandom} % span);
    endfunction

    task automatic random_phase(int n);
        int          r;
        int          z;
        logic [63:0] len;
        for (int i = 0; i < n; i++) begin
            r = $urandom_range(0, 99);
            z = $urandom_range(0, 2);
            len = 64'($urandom_range(0, 8)) * PG + 64'($urandom_range(0, 4095));
            if ($urandom_range(0, 49) == 0) len = rand48();
            if (r < 35)      send_req(zbpa_pkg::OP_ALLOC, rand48(), rand48());
            else if (r < 60) send_req(zbpa_pkg::OP_FREE_PAGE, zone_addr(z), rand48());
            else if (r < 78) send_req(zbpa_pkg::OP_RESERVE_RNG, zone_addr(z), len);
            else             send_req(zbpa_pkg::OP_FREE_RNG, zone_addr(z), len);
        end
    endtask

    task automatic open_zones();
        for (int z = 0; z < 3; z++)
            if (ze[z] > zs[z]) send_req(zbpa_pkg::OP_FREE_RNG, zs[z], ze[z] - zs[z]);
    endtask

    initial begin
        zs = '{default: 0};
        ze = '{default: 0};
        repeat (8) @(negedge aclk);
        aresetn <= 1'b1;

        // no zones configured
        send_req(zbpa_pkg::OP_ALLOC, 0, 0);
        send_req(zbpa_pkg::OP_FREE_PAGE, AMASK, 0);
        send_req(zbpa_pkg::OP_RESERVE_RNG, 0, 0);
        send_req(zbpa_pkg::OP_FREE_RNG, AMASK, AMASK);
        drain();

        // small zones, unaligned start, one at the top of the address space
        set_zones(64'h1000, 64'h1000 + 64 * PG, 64'h10_0123, 64'h10_0123 + 100 * PG,
                  64'hFFFF_FFFF_0000, AMASK);
        send_req(zbpa_pkg::OP_ALLOC, 0, 0);
        open_zones();
        for (int i = 0; i < 4; i++) send_req(zbpa_pkg::OP_ALLOC, 0, 0);
        send_req(zbpa_pkg::OP_FREE_PAGE, 64'h1000 + PG + 64'h7FF, 0);
        send_req(zbpa_pkg::OP_ALLOC, 0, 0);
        send_req(zbpa_pkg::OP_RESERVE_RNG, 64'h1000, 64 * PG);
        send_req(zbpa_pkg::OP_ALLOC, 0, 0);
        send_req(zbpa_pkg::OP_RESERVE_RNG, 64'hFFFF_FFFF_0ABC, AMASK);
        send_req(zbpa_pkg::OP_FREE_RNG, 64'h1000 + 63 * PG, 3 * PG);
        send_req(zbpa_pkg::OP_FREE_PAGE, 64'h500, 0);
        send_req(zbpa_pkg::OP_FREE_RNG, 64'hFFFF_FFFF_0000, 64'hFFFF);
        random_phase(280);
        drain();

        // oversized zone, empty zone
        set_zones(0, 64'h200_0000, 64'h500_0000, 64'h400_0000,
                  64'h300_0000, 64'h300_0000 + 32 * PG);
        send_req(zbpa_pkg::OP_FREE_RNG, 0, 64 * PG);
        send_req(zbpa_pkg::OP_FREE_RNG, 64'h300_0000, 32 * PG);
        send_req(zbpa_pkg::OP_FREE_PAGE, 4096 * PG, 0);
        send_req(zbpa_pkg::OP_FREE_RNG, 4095 * PG + 64'h10, 2 * PG);
        send_req(zbpa_pkg::OP_FREE_PAGE, 64'h480_0000, 0);
        send_req(zbpa_pkg::OP_ALLOC, 0, 0);
        random_phase(270);
        drain();

        // overlapping zones, upper register bits set
        set_zones(64'hABCD_FFFF_FFFF_F000, AMASK, 0, 64'h4_0000,
                  64'h3_F800, 64'h8_0000);
        open_zones();
        send_req(zbpa_pkg::OP_FREE_PAGE, 64'h3_F900, 0);
        send_req(zbpa_pkg::OP_RESERVE_RNG, 64'h3_F000, 8 * PG);
        random_phase(270);
        drain();

        set_zones(0, 0, 0, 0, 0, 0);
        random_phase(250);
        drain();

        if (fail_count == 0 && pending_count == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
